[rtl/core/x11af_pkg.sv]
`timescale 1ns / 1ps
package x11af_pkg;

	// longest cookie the comparator accepts
	localparam int unsigned COOKIE_BYTES = 16;

	localparam int unsigned HDR_BYTES = 12;
	localparam int unsigned NAME_LEN  = 18;
	localparam int unsigned TEXT_LEN  = 40;

	localparam logic [7:0] BYTE_ORDER_BIG = 8'h42;  // 'B'
	localparam logic [7:0] PAD_CHAR       = 8'h2e;  // '.'

	localparam logic [8*NAME_LEN-1:0] AUTH_NAME = "MIT-MAGIC-COOKIE-1";
	localparam logic [8*TEXT_LEN-1:0] FAIL_TEXT = "Authentication failed at X11 auth filter";

	typedef enum logic [1:0] {
		PH_SETUP,
		PH_PASS,
		PH_CLOSED
	} phase_t;

	typedef enum logic [1:0] {
		CMD_PASS,
		CMD_OK,
		CMD_FAIL
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
	} cmd_t;

	function automatic logic [7:0] name_char(input logic [4:0] i);
		return AUTH_NAME[8*(NAME_LEN-1-i) +: 8];
	endfunction

	function automatic logic [7:0] reason_char(input logic [5:0] i);
		return FAIL_TEXT[8*(TEXT_LEN-1-i) +: 8];
	endfunction

endpackage

[rtl/core/x11af_front.sv]
`timescale 1ns / 1ps
module x11af_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [63:0]         cfg_wdata,
	input  logic                in_valid,
	input  logic [7:0]          in_byte,
	output logic                in_ready,
	input  logic                q_full,
	output logic                q_push,
	output x11af_pkg::cmd_t     q_cmd,
	output logic [7:0]          hdr [x11af_pkg::HDR_BYTES]
);
	import x11af_pkg::*;

	localparam logic [1:0] REG_COOKIE_LOW  = 2'd0;
	localparam logic [1:0] REG_COOKIE_HIGH = 2'd1;
	localparam logic [1:0] REG_COOKIE_LEN  = 2'd2;

	logic [63:0]  cookie_low_q;
	logic [63:0]  cookie_high_q;
	logic [4:0]   cookie_length_q;

	phase_t       phase_q, phase_d;
	logic [17:0]  byte_count_q;
	logic [7:0]   hdr_q [HDR_BYTES];
	logic [15:0]  name_len_q;
	logic [15:0]  cookie_len_q;
	logic [16:0]  name_pad_q;
	logic [17:0]  end_q;
	logic [16:0]  sect_idx_q;
	logic         in_cookie_q;
	logic         name_match_q, name_ended_q, cookie_match_q;

	logic         accept;
	logic         big_endian;
	logic [15:0]  nl_w, cl_w;
	logic [16:0]  npad_w, cpad_w;
	logic [17:0]  count_inc;
	logic         decide, ok;
	logic         nm_d, ne_d, cm_d;
	logic [127:0] cookie_all;
	logic [7:0]   cookie_b;

	assign in_ready   = !q_full;
	assign accept     = in_valid && in_ready;
	assign big_endian = (hdr_q[0] == BYTE_ORDER_BIG);
	assign cookie_all = {cookie_high_q, cookie_low_q};
	assign cookie_b   = cookie_all[{sect_idx_q[3:0], 3'b000} +: 8];
	assign count_inc  = 18'(byte_count_q + 18'd1);

	// lengths from header bytes 6..9, valid once ten bytes are in
	always_comb begin
		nl_w   = big_endian ? {hdr_q[6], hdr_q[7]} : {hdr_q[7], hdr_q[6]};
		cl_w   = big_endian ? {hdr_q[8], hdr_q[9]} : {hdr_q[9], hdr_q[8]};
		npad_w = 17'(({1'b0, nl_w} + 17'd3) & ~17'd3);
		cpad_w = 17'(({1'b0, cl_w} + 17'd3) & ~17'd3);
	end

	// match flags after the current byte
	always_comb begin
		nm_d = name_match_q;
		ne_d = name_ended_q;
		cm_d = cookie_match_q;
		if (byte_count_q >= 18'(HDR_BYTES)) begin
			if (!in_cookie_q) begin
				if (sect_idx_q < {1'b0, name_len_q} && !name_ended_q) begin
					if (in_byte == 8'h00) begin
						ne_d = 1'b1;
						if (sect_idx_q != 17'(NAME_LEN))
							nm_d = 1'b0;
					end else if (sect_idx_q >= 17'(NAME_LEN)
						|| in_byte != name_char(sect_idx_q[4:0])) begin
						nm_d = 1'b0;
					end
				end
			end else if (sect_idx_q < {1'b0, cookie_len_q}) begin
				if (sect_idx_q >= 17'(COOKIE_BYTES) || in_byte != cookie_b)
					cm_d = 1'b0;
			end
		end
	end

	assign decide = accept && phase_q == PH_SETUP
		&& byte_count_q >= 18'(HDR_BYTES - 1) && count_inc >= end_q;
	assign ok = nm_d && (ne_d || name_len_q == 16'(NAME_LEN)) && cm_d
		&& cookie_len_q == {11'd0, cookie_length_q}
		&& cookie_length_q <= 5'(COOKIE_BYTES);

	// phase next state
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_SETUP:  if (decide) phase_d = ok ? PH_PASS : PH_CLOSED;
			PH_PASS:   phase_d = PH_PASS;
			PH_CLOSED: phase_d = PH_CLOSED;
			default:   phase_d = PH_CLOSED;
		endcase
	end

	// queue writes
	always_comb begin
		q_push      = 1'b0;
		q_cmd.kind  = CMD_PASS;
		q_cmd.data  = in_byte;
		unique case (phase_q)
			PH_SETUP: begin
				q_push     = decide;
				q_cmd.kind = ok ? CMD_OK : CMD_FAIL;
			end
			PH_PASS:   q_push = accept;
			PH_CLOSED: q_push = 1'b0;
			default:   q_push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cookie_low_q    <= '0;
			cookie_high_q   <= '0;
			cookie_length_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COOKIE_LOW:  cookie_low_q    <= cfg_wdata;
				REG_COOKIE_HIGH: cookie_high_q   <= cfg_wdata;
				REG_COOKIE_LEN:  cookie_length_q <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_SETUP;
			byte_count_q   <= '0;
			name_len_q     <= '0;
			cookie_len_q   <= '0;
			name_pad_q     <= '0;
			end_q          <= 18'(HDR_BYTES);
			sect_idx_q     <= '0;
			in_cookie_q    <= 1'b0;
			name_match_q   <= 1'b1;
			name_ended_q   <= 1'b0;
			cookie_match_q <= 1'b1;
		end else begin
			phase_q <= phase_d;
			if (accept && phase_q == PH_SETUP) begin
				byte_count_q   <= count_inc;
				name_match_q   <= nm_d;
				name_ended_q   <= ne_d;
				cookie_match_q <= cm_d;
				if (byte_count_q == 18'(HDR_BYTES - 2)) begin
					name_len_q   <= nl_w;
					cookie_len_q <= cl_w;
					name_pad_q   <= npad_w;
					end_q        <= 18'(18'(HDR_BYTES) + {1'b0, npad_w} + {1'b0, cpad_w});
					in_cookie_q  <= (npad_w == '0);
					sect_idx_q   <= '0;
				end else if (byte_count_q >= 18'(HDR_BYTES)) begin
					if (!in_cookie_q && sect_idx_q == 17'(name_pad_q - 17'd1)) begin
						in_cookie_q <= 1'b1;
						sect_idx_q  <= '0;
					end else begin
						sect_idx_q <= 17'(sect_idx_q + 17'd1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && phase_q == PH_SETUP && byte_count_q < 18'(HDR_BYTES))
			hdr_q[byte_count_q[3:0]] <= in_byte;
	end

	assign hdr = hdr_q;

endmodule

[rtl/core/x11af_cmdq.sv]
`timescale 1ns / 1ps
module x11af_cmdq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  x11af_pkg::cmd_t  push_cmd,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output x11af_pkg::cmd_t  head
);
	import x11af_pkg::*;

	localparam int unsigned DEPTH = 2;
	localparam int unsigned PW    = $clog2(DEPTH);
	localparam int unsigned CW    = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= PW'(wr_ptr_q + PW'(1));
			if (pop)
				rd_ptr_q <= PW'(rd_ptr_q + PW'(1));
			if (push && !pop)
				count_q <= CW'(count_q + CW'(1));
			else if (pop && !push)
				count_q <= CW'(count_q - CW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

endmodule

[rtl/core/x11af_back.sv]
`timescale 1ns / 1ps
module x11af_back #(
	parameter int unsigned REASON_BYTES = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  x11af_pkg::cmd_t  q_head,
	output logic             q_pop,
	input  logic [7:0]       hdr [x11af_pkg::HDR_BYTES],
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             out_to_client,
	output logic             out_close,
	output logic             out_last
);
	import x11af_pkg::*;

	localparam int unsigned MSIZE     = (REASON_BYTES + 3) / 4 * 4;
	localparam int unsigned REPLY_LEN = 8 + MSIZE;
	localparam int unsigned CW        = $clog2(REPLY_LEN + 1);

	logic [CW-1:0] idx_q;
	logic          valid_q;
	logic [7:0]    byte_q;
	logic          toc_q, close_q, last_q;

	logic          load;
	logic          big_endian;
	logic [8:0]    rsn_idx;
	logic [7:0]    g_byte;
	logic          g_toc, g_close, g_last;

	assign big_endian = (hdr[0] == BYTE_ORDER_BIG);
	assign load       = !q_empty && (!valid_q || out_ready);
	assign q_pop      = load && g_last;
	assign rsn_idx    = 9'(9'(idx_q) - 9'd8);

	always_comb begin
		g_byte  = '0;
		g_toc   = 1'b0;
		g_close = 1'b0;
		g_last  = 1'b0;
		unique case (q_head.kind)
			CMD_PASS: begin
				g_byte = q_head.data;
				g_last = 1'b1;
			end
			CMD_OK: begin
				// header forwarded with both length fields zeroed
				if (idx_q < CW'(6) || (idx_q > CW'(9) && idx_q < CW'(HDR_BYTES)))
					g_byte = hdr[idx_q[3:0]];
				g_last = (idx_q == CW'(HDR_BYTES - 1));
			end
			CMD_FAIL: begin
				g_toc = 1'b1;
				priority if (idx_q == CW'(0))
					g_byte = 8'h00;
				else if (idx_q == CW'(1))
					g_byte = 8'(REASON_BYTES);
				else if (idx_q < CW'(6))
					g_byte = hdr[idx_q[3:0]];
				else if (idx_q == CW'(6))
					g_byte = big_endian ? 8'h00 : 8'(MSIZE >> 2);
				else if (idx_q == CW'(7))
					g_byte = big_endian ? 8'(MSIZE >> 2) : 8'h00;
				else if (rsn_idx < 9'(REASON_BYTES))
					g_byte = (rsn_idx < 9'(TEXT_LEN)) ? reason_char(rsn_idx[5:0]) : PAD_CHAR;
				else
					g_byte = 8'h00;
				g_last  = (idx_q == CW'(REPLY_LEN - 1));
				g_close = g_last;
			end
			default: g_last = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= g_last ? '0 : CW'(idx_q + CW'(1));
			if (load)
				valid_q <= 1'b1;
			else if (out_ready)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q  <= g_byte;
			toc_q   <= g_toc;
			close_q <= g_close;
			last_q  <= g_last;
		end
	end

	assign out_valid     = valid_q;
	assign out_byte      = byte_q;
	assign out_to_client = toc_q;
	assign out_close     = close_q;
	assign out_last      = last_q;

endmodule

[rtl/core/x11_setup_auth_filter.sv]
`timescale 1ns / 1ps
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata = client byte
// m_*       out  m_tvalid/m_tready  m_tdata = byte, m_tuser = direction/close, m_tlast
// cfg_*     in   cfg_we             cfg_index selects register, cfg_wdata value
//
// passthrough sustains one byte per cycle while m_tready is high; a setup byte with
// no result takes no queue entry; the setup decision expands into 12 header bytes
// or 8 + pad4(REASON_BYTES) reply bytes, one per cycle from the back-end byte counter
// if m_tready is high; the front stalls only when the two-entry request queue is full
// arst_n clears all control state at once; there is no clearing pass
// after a failed authentication every later byte is taken and dropped until reset
module x11_setup_auth_filter #(
	parameter int unsigned REASON_BYTES = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic [1:0]  m_tuser,   // [0] to_client, [1] close_link
	output logic        m_tlast
);
	import x11af_pkg::*;

	// front to back request queue
	logic       q_push, q_pop, q_full, q_empty;
	cmd_t       q_in, q_head;

	// captured setup header, stable once the decision is queued
	logic [7:0] hdr [HDR_BYTES];

	// front: header capture, name/cookie matching, decision
	x11af_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_byte   (s_tdata),
		.in_ready  (s_tready),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (q_in),
		.hdr       (hdr)
	);

	// short queue so front and back stall independently
	x11af_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	// back: expands each request into output bytes behind an output register
	x11af_back #(
		.REASON_BYTES (REASON_BYTES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.hdr           (hdr),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_byte      (m_tdata),
		.out_to_client (m_tuser[0]),
		.out_close     (m_tuser[1]),
		.out_last      (m_tlast)
	);

`ifndef SYNTHESIS
	// no request may be written into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("request queue overflow");

	// no request may be taken from an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !q_empty)
		else $error("request queue underflow");

	// close is flagged only on the final byte of a reply to the client
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast && m_tuser[0])
		else $error("close flagged off the last reply byte");

	// no request is queued straight after a close goes out
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser[1] |=> !q_push)
		else $error("request queued after close");
`endif

endmodule
